@@ rtl/core/radial_hazard_field_sum_unit_macros.svh @@
// assertion macros shared by the rtl
`ifndef RADIAL_HAZARD_FIELD_SUM_UNIT_MACROS_SVH
`define RADIAL_HAZARD_FIELD_SUM_UNIT_MACROS_SVH
// a implies b in the same cycle
`define RHF_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b in the next cycle
`define RHF_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`endif

@@ rtl/core/rhf_pkg.sv @@
// ---------------------------------------------------------------------------
// rhf_pkg
// types and constants for the radial hazard field sum unit
// ---------------------------------------------------------------------------
package rhf_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned DangerW = 22;
  localparam logic [DangerW-1:0] DangerMax = 22'h3FFFFF;
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_SQRT, ST_CHECK, ST_DIV, ST_ACC, ST_OUT
  } rhf_state_t;

  // control from sequencer to the shared datapath
  typedef struct packed {
    logic start_sqrt;
    logic start_div;
  } rhf_ctrl_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } rhf_stat_t;
endpackage

@@ rtl/core/rhf_shift_unit.sv @@
// ---------------------------------------------------------------------------
// rhf_shift_unit
// shared shift-subtract unit: 33-bit integer square root (1 bit/cycle) and
// 32/16 restoring division (1 bit/cycle)
// ---------------------------------------------------------------------------
module rhf_shift_unit
  import rhf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rhf_ctrl_t   ctrl,
  input  logic [32:0] sq_val,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic [16:0] root,
  output logic [31:0] quot,
  output rhf_stat_t   stat
);
  logic        busy_r, busy_nxt, mode_r, mode_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [33:0] acc_r, acc_nxt;   // sqrt: operand bits; div: quotient
  logic [16:0] root_r, root_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic [33:0] rsh;

  always_comb begin
    busy_nxt = busy_r; mode_nxt = mode_r; cnt_nxt = cnt_r; rem_nxt = rem_r;
    acc_nxt = acc_r; root_nxt = root_r; dvs_nxt = dvs_r; done_nxt = 1'b0;
    trial = '0; rsh = '0;
    if (ctrl.start_sqrt) begin
      busy_nxt = 1'b1; mode_nxt = 1'b0; cnt_nxt = 6'd17;
      rem_nxt = '0; acc_nxt = {1'b0, sq_val}; root_nxt = '0;
    end else if (ctrl.start_div) begin
      busy_nxt = 1'b1; mode_nxt = 1'b1; cnt_nxt = 6'd32;
      rem_nxt = '0; acc_nxt = {2'b0, dividend}; dvs_nxt = divisor;
    end else if (busy_r) begin
      if (!mode_r) begin
        // digit recurrence: bring in two bits, try 4*root+1
        rsh = {rem_r[31:0], acc_r[33:32]};
        trial = {15'd0, root_r, 2'b01};
        acc_nxt = {acc_r[31:0], 2'b00};
        if (rsh >= trial) begin
          rem_nxt = rsh - trial; root_nxt = {root_r[15:0], 1'b1};
        end else begin
          rem_nxt = rsh; root_nxt = {root_r[15:0], 1'b0};
        end
      end else begin
        rsh = {rem_r[32:0], acc_r[31]};
        trial = {18'd0, dvs_r};
        if (rsh >= trial) begin
          rem_nxt = rsh - trial; acc_nxt = {acc_r[32:0], 1'b1};
        end else begin
          rem_nxt = rsh; acc_nxt = {acc_r[32:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    mode_r <= mode_nxt; rem_r <= rem_nxt; acc_r <= acc_nxt;
    root_r <= root_nxt; dvs_r <= dvs_nxt;
  end

  assign root = root_r;
  assign quot = acc_r[31:0];
  assign stat.sqrt_done = done_r & ~mode_r;
  assign stat.div_done = done_r & mode_r;
endmodule

@@ rtl/core/radial_hazard_field_sum_unit.sv @@
// ---------------------------------------------------------------------------
// radial_hazard_field_sum_unit
// sums clamped radial hazard terms of stored points at a query position
// ---------------------------------------------------------------------------
// input channel: in_valid/in_stall with cmd, index, position, radius, weight.
// a load transaction writes one table entry and gives no result.
// a query transaction walks entries 0..active_points-1 (saturated to
// MAX_POINTS); per entry: one table read, a difference/square step, a
// 17-step square root and, for points within range, a 32-step division on
// the shared shift-subtract unit. the result waits in an output register
// (out_valid/out_danger) until out_stall is low; in_stall stays high while
// a query runs or its result is held. reset clears the sequencer and sets
// active_points to 0; table contents are undefined until loaded.
// cfg_we writes active_points from cfg_wdata.
// ---------------------------------------------------------------------------
`include "radial_hazard_field_sum_unit_macros.svh"
module radial_hazard_field_sum_unit
  import rhf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         in_cmd,
  input  logic [5:0]   in_index,
  input  logic [15:0]  in_pos_x,
  input  logic [15:0]  in_pos_y,
  input  logic [15:0]  in_radius,
  input  logic [15:0]  in_weight,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [DangerW-1:0] out_danger,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rd_r;
  rhf_state_t state_r, state_nxt;
  logic [6:0] active_r;
  logic [CW-1:0] k_r, k_nxt, cnt_lim;
  logic [15:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [32:0] d2_r, d2_nxt;
  logic [31:0] num_r, num_nxt;
  logic [22:0] sum_r, sum_nxt;
  logic out_valid_r, out_valid_nxt;
  rhf_ctrl_t ctrl;
  rhf_stat_t stat;
  logic [16:0] root;
  logic [31:0] quot;
  logic [15:0] px, py, pr, pw, dx, dy;
  logic accept, rd_en;
  logic [22:0] qsum;

  assign accept = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE) | out_valid_r;
  assign {px, py, pr, pw} = rd_r;
  assign cnt_lim = (32'(active_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(active_r);

  always_ff @(posedge clk) begin
    if (accept && in_cmd == CmdLoad && 32'(in_index) < MAX_POINTS)
      mem[AW'(in_index)] <= {in_pos_x, in_pos_y, in_radius, in_weight};
    if (rd_en) rd_r <= mem[k_r[AW-1:0]];
  end

  // the root starts on the squared distance as it is formed
  rhf_shift_unit u_shift (
    .clk, .rst_n, .ctrl, .sq_val(d2_nxt), .dividend(num_r), .divisor(pr),
    .root, .quot, .stat
  );

  always_comb begin
    state_nxt = state_r; k_nxt = k_r; qx_nxt = qx_r; qy_nxt = qy_r;
    d2_nxt = d2_r; num_nxt = num_r; sum_nxt = sum_r;
    out_valid_nxt = out_valid_r; ctrl = '0; rd_en = 1'b0;
    dx = (qx_r >= px) ? qx_r - px : px - qx_r;
    dy = (qy_r >= py) ? qy_r - py : py - qy_r;
    qsum = sum_r + {7'd0, quot[15:0]};
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CmdQuery) begin
          qx_nxt = in_pos_x; qy_nxt = in_pos_y; k_nxt = '0; sum_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (k_r >= cnt_lim) state_nxt = ST_OUT;
        else begin
          rd_en = 1'b1; state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        d2_nxt = 33'(32'(dx) * 32'(dx)) + 33'(32'(dy) * 32'(dy));
        state_nxt = ST_SQRT; ctrl.start_sqrt = 1'b1;
      end
      ST_SQRT: if (stat.sqrt_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (pr == '0 || root >= {1'b0, pr}) begin
          k_nxt = k_r + 1'b1; state_nxt = ST_READ;
        end else begin
          num_nxt = 32'(pw) * 32'(pr - root[15:0]);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        ctrl.start_div = 1'b1; state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (stat.div_done) begin
          // term at most weight, fits in 16 bits; saturate the sum
          sum_nxt = (qsum > {1'b0, DangerMax}) ? {1'b0, DangerMax} : qsum;
          k_nxt = k_r + 1'b1; state_nxt = ST_READ;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; out_valid_r <= 1'b0; active_r <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_we) active_r <= cfg_wdata;
    end
    k_r <= k_nxt; qx_r <= qx_nxt; qy_r <= qy_nxt; d2_r <= d2_nxt;
    num_r <= num_nxt; sum_r <= sum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_danger = sum_r[DangerW-1:0];

  `RHF_ASSERT_IMPL(a_sum_sat, state_r != ST_IDLE, sum_r <= {1'b0, DangerMax})
  `RHF_ASSERT_IMPL(a_stall_busy, state_r != ST_IDLE, in_stall)
  `RHF_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(sum_r))
endmodule
